[sv/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types and constants of the message chunk segmenter
// ----------------------------------------------------------------------------
package mcs_pkg;

    // default sizing
    localparam int unsigned CHUNK_DATA_DEF = 19;
    localparam int unsigned MAX_MSG_DEF    = 255;

    // slot index width, covers the largest chunk size of 62 plus one
    localparam int unsigned POS_W = 6;

    // command queue depth
    localparam int unsigned QDEPTH = 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE     = 3'd4;

    // reset values of the configuration registers
    localparam logic [7:0] FLAGS_BASE_RST   = 8'd0;
    localparam logic [7:0] START_MASK_RST   = 8'd1;
    localparam logic [7:0] END_MASK_RST     = 8'd2;
    localparam logic [7:0] ENCRYPT_MASK_RST = 8'd4;
    localparam logic [7:0] PAD_BYTE_RST     = 8'd0;

    typedef struct packed {
        logic [7:0] flags_base;
        logic [7:0] start_mask;
        logic [7:0] end_mask;
        logic [7:0] encrypt_mask;
        logic [7:0] pad_byte;
    } cfg_t;

    // one classified input item, as handed from front to back
    typedef struct packed {
        logic             err;       // bad length, single error result
        logic             has_len;   // message start, length byte goes first
        logic [7:0]       len;
        logic [7:0]       data;
        logic [POS_W-1:0] pad_cnt;   // pad bytes after the data byte
        logic             has_flag;  // chunk closes after this item
        logic             first;     // closing chunk is the message's first
        logic             enc;
        logic             last;      // closing chunk is the message's last
    } cmd_t;

endpackage

[sv/mcs_if.sv]
// ----------------------------------------------------------------------------
// mcs_in_if / mcs_out_if
// valid/ready channels of the message chunk segmenter
// ----------------------------------------------------------------------------
interface mcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] msg_len;
    logic       encrypted;

    modport source (output valid, output data_byte, output msg_len, output encrypted,
                    input ready);
    modport sink   (input valid, input data_byte, input msg_len, input encrypted,
                    output ready);
endinterface

interface mcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       msg_end;
    logic       length_error;
    logic       run_last;

    modport source (output valid, output out_byte, output chunk_end, output msg_end,
                    output length_error, output run_last, input ready);
    modport sink   (input valid, input out_byte, input chunk_end, input msg_end,
                    input length_error, input run_last, output ready);
endinterface

[sv/mcs_front.sv]
// ----------------------------------------------------------------------------
// mcs_front
// accepts message bytes, tracks message and chunk position, builds commands
// ----------------------------------------------------------------------------
module mcs_front #(
    parameter int unsigned CHUNK_DATA = mcs_pkg::CHUNK_DATA_DEF,
    parameter int unsigned MAX_MSG    = mcs_pkg::MAX_MSG_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mcs_in_if.sink        msg,
    output mcs_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import mcs_pkg::*;

    localparam logic [POS_W-1:0] CD_P  = POS_W'(CHUNK_DATA);
    localparam logic [7:0]       MAX_P = 8'(MAX_MSG);

    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0] chunk_pos_reg, chunk_pos_next;
    logic             first_chunk_reg, first_chunk_next;
    logic             enc_latched_reg, enc_latched_next;

    logic             idle, bad, last, closes, fc, enc, take;
    logic [POS_W-1:0] pos0, pos1, pads;
    logic [7:0]       bl;

    always_comb
    begin
        idle   = (bytes_left_reg == 8'd0);
        bad    = idle && ((msg.msg_len == 8'd0) || (msg.msg_len > MAX_P));
        pos0   = idle ? POS_W'(1) : chunk_pos_reg;
        bl     = idle ? msg.msg_len : bytes_left_reg;
        pos1   = pos0 + POS_W'(1);
        last   = (bl == 8'd1);
        pads   = (last && (pos1 < CD_P)) ? (CD_P - pos1) : '0;
        closes = last || (pos1 >= CD_P);
        fc     = idle ? 1'b1 : first_chunk_reg;
        enc    = idle ? msg.encrypted : enc_latched_reg;
        take   = msg.valid && cmd_ready;

        bytes_left_next  = bytes_left_reg;
        chunk_pos_next   = chunk_pos_reg;
        first_chunk_next = first_chunk_reg;
        enc_latched_next = enc_latched_reg;
        if (take && !bad)
        begin
            bytes_left_next  = bl - 8'd1;
            chunk_pos_next   = closes ? '0 : pos1;
            first_chunk_next = closes ? last : fc;
            enc_latched_next = enc;
        end

        cmd.err      = bad;
        cmd.has_len  = idle;
        cmd.len      = msg.msg_len;
        cmd.data     = msg.data_byte;
        cmd.pad_cnt  = pads;
        cmd.has_flag = closes;
        cmd.first    = fc;
        cmd.enc      = enc;
        cmd.last     = last;
    end

    assign cmd_valid = msg.valid;
    assign msg.ready = cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            chunk_pos_reg   <= '0;
            first_chunk_reg <= 1'b1;
            enc_latched_reg <= 1'b0;
        end
        else
        begin
            bytes_left_reg  <= bytes_left_next;
            chunk_pos_reg   <= chunk_pos_next;
            first_chunk_reg <= first_chunk_next;
            enc_latched_reg <= enc_latched_next;
        end
    end

endmodule

[sv/mcs_queue.sv]
// ----------------------------------------------------------------------------
// mcs_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module mcs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  mcs_pkg::cmd_t wr_cmd,
    input  logic          wr_valid,
    output logic          wr_ready,
    output mcs_pkg::cmd_t rd_cmd,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import mcs_pkg::*;

    localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    cmd_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[sv/mcs_back.sv]
// ----------------------------------------------------------------------------
// mcs_back
// expands commands to len/data/pad/flag/error bytes, one per unstalled cycle
// ----------------------------------------------------------------------------
module mcs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mcs_pkg::cfg_t cfg,
    input  mcs_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    mcs_out_if.source     chunks
);
    import mcs_pkg::*;

    typedef enum logic [1:0] {
        ST_START,
        ST_DATA,
        ST_PAD,
        ST_FLAG
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pad_cnt_reg, pad_cnt_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       chunk_end_reg, msg_end_reg, length_error_reg, run_last_reg;

    logic       load, emit;
    logic [7:0] nb, flag_val;
    logic       nce, nme, nle, nrl;

    assign load = !out_valid_reg || chunks.ready;
    assign emit = cmd_valid && load;

    always_comb
    begin
        flag_val = cfg.flags_base
                 | (cmd.enc   ? cfg.encrypt_mask : 8'd0)
                 | (cmd.first ? cfg.start_mask   : 8'd0)
                 | (cmd.last  ? cfg.end_mask     : 8'd0);

        phase_next   = phase_reg;
        pad_cnt_next = pad_cnt_reg;
        nb  = '0;
        nce = 1'b0;
        nme = 1'b0;
        nle = 1'b0;
        nrl = 1'b0;

        unique case (phase_reg)
            ST_START,
            ST_DATA:
            begin
                if (phase_reg == ST_START && cmd.err)
                begin
                    nle = 1'b1;
                    nrl = 1'b1;
                end
                else if (phase_reg == ST_START && cmd.has_len)
                begin
                    nb         = cmd.len;
                    phase_next = ST_DATA;
                end
                else
                begin
                    nb = cmd.data;
                    if (cmd.pad_cnt != '0)
                    begin
                        phase_next   = ST_PAD;
                        pad_cnt_next = cmd.pad_cnt;
                    end
                    else if (cmd.has_flag)
                    begin
                        phase_next = ST_FLAG;
                    end
                    else
                    begin
                        phase_next = ST_START;
                        nrl        = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                nb           = cfg.pad_byte;
                pad_cnt_next = pad_cnt_reg - POS_W'(1);
                if (pad_cnt_reg == POS_W'(1))
                begin
                    phase_next = cmd.has_flag ? ST_FLAG : ST_START;
                    nrl        = !cmd.has_flag;
                end
            end
            ST_FLAG:
            begin
                nb         = flag_val;
                nce        = 1'b1;
                nme        = cmd.last;
                nrl        = 1'b1;
                phase_next = ST_START;
            end
            default:
            begin
                phase_next = ST_START;
            end
        endcase
    end

    assign cmd_pop = emit && nrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_START;
            pad_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                phase_reg   <= phase_next;
                pad_cnt_reg <= pad_cnt_next;
            end
            if (load)
            begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg     <= nb;
            chunk_end_reg    <= nce;
            msg_end_reg      <= nme;
            length_error_reg <= nle;
            run_last_reg     <= nrl;
        end
    end

    assign chunks.valid        = out_valid_reg;
    assign chunks.out_byte     = out_byte_reg;
    assign chunks.chunk_end    = chunk_end_reg;
    assign chunks.msg_end      = msg_end_reg;
    assign chunks.length_error = length_error_reg;
    assign chunks.run_last     = run_last_reg;

endmodule

[sv/message_chunk_segmenter.sv]
// ----------------------------------------------------------------------------
// message_chunk_segmenter
// cuts a byte-wise message into fixed-size chunks with length and flag bytes
// ----------------------------------------------------------------------------
// A message enters one data byte per transfer on msg; msg_len and encrypted
// count only on the first byte of a message. The chunk stream leaves on chunks,
// one byte per transfer, and run_last marks the last byte caused by an input
// transfer. Each chunk is CHUNK_DATA payload slots and one flag byte; the first
// chunk opens with the length byte, the last one is filled up with pad_byte.
// A length of zero or above MAX_MSG gives a single length_error transfer and
// the byte is dropped. The front accepts one input per cycle while the
// two-entry command queue has room; the back end writes one output byte per
// cycle into its output register unless stalled, so an input holds the back
// end for each byte it causes: its data byte, a length byte when it opens a
// message, pad bytes when it ends a message early in a chunk and a flag byte
// when it closes a chunk. With plain data bytes and no stall the block runs at
// one byte per cycle. An input passes the command queue and then the output
// register. The user writes configuration registers via cfg_we/cfg_index/
// cfg_data only with no message byte in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module message_chunk_segmenter #(
    parameter int unsigned CHUNK_DATA = mcs_pkg::CHUNK_DATA_DEF,
    parameter int unsigned MAX_MSG    = mcs_pkg::MAX_MSG_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    mcs_in_if.sink                         msg,
    mcs_out_if.source                      chunks
);
    import mcs_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // front to queue
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;

    // queue to back
    cmd_t head_cmd;
    logic head_valid;
    logic head_pop;

    // register writes; an index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flags_base   <= FLAGS_BASE_RST;
            cfg_reg.start_mask   <= START_MASK_RST;
            cfg_reg.end_mask     <= END_MASK_RST;
            cfg_reg.encrypt_mask <= ENCRYPT_MASK_RST;
            cfg_reg.pad_byte     <= PAD_BYTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLAGS_BASE:   cfg_reg.flags_base   <= cfg_data;
                CFG_START_MASK:   cfg_reg.start_mask   <= cfg_data;
                CFG_END_MASK:     cfg_reg.end_mask     <= cfg_data;
                CFG_ENCRYPT_MASK: cfg_reg.encrypt_mask <= cfg_data;
                CFG_PAD_BYTE:     cfg_reg.pad_byte     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // classify each input transfer and keep message / chunk position
    mcs_front #(
        .CHUNK_DATA (CHUNK_DATA),
        .MAX_MSG    (MAX_MSG)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // decouples input acceptance from multi-byte expansion
    mcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid),
        .rd_ready (head_pop)
    );

    // byte sequencer with output register
    mcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (head_pop),
        .chunks    (chunks)
    );

endmodule

[sv/mcs_checker.sv]
// ----------------------------------------------------------------------------
// mcs_checker
// port-level checks of the message chunk segmenter output stream
// ----------------------------------------------------------------------------
module mcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       chunk_end,
    input logic       msg_end,
    input logic       length_error,
    input logic       run_last
);

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled output transfer changed");

    // error result is a lone zero byte
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> out_byte == 8'd0 && !chunk_end && !msg_end && run_last)
        else $error("malformed length error result");

    // message end only on a flag byte
    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && msg_end |-> chunk_end)
        else $error("msg_end outside a flag byte");

    // a flag byte is always the last byte of its input transfer
    a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_end |-> run_last)
        else $error("flag byte not last of its run");

endmodule

bind message_chunk_segmenter mcs_checker u_mcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (chunks.valid),
    .out_ready    (chunks.ready),
    .out_byte     (chunks.out_byte),
    .chunk_end    (chunks.chunk_end),
    .msg_end      (chunks.msg_end),
    .length_error (chunks.length_error),
    .run_last     (chunks.run_last)
);
